/* rtl/afrle_pkg.sv */
package afrle_pkg;

    localparam int unsigned DIGIT_CAP = 99999;
    localparam int VAL_W = 17;
    localparam int POS_W = 3;
    localparam int QDEPTH = 4;

    localparam logic [7:0] UC_BELOW = 8'd64;
    localparam logic [7:0] UC_ABOVE = 8'd91;
    localparam logic [7:0] LC_BELOW = 8'd96;
    localparam logic [7:0] LC_ABOVE = 8'd123;
    localparam logic [7:0] ASCII_ZERO = 8'd48;
    localparam int unsigned RADIX = 10;

    typedef struct packed {
        logic [7:0]       letter;
        logic [VAL_W-1:0] len;
        logic             last;
        logic             chunk;
    } rle_cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIGIT,
        BK_REPEAT,
        BK_LETTER
    } back_state_t;

    function automatic logic is_letter(input logic [7:0] b);
        return (b > UC_BELOW && b < UC_ABOVE) || (b > LC_BELOW && b < LC_ABOVE);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= ASCII_ZERO) && (b < ASCII_ZERO + 8'(RADIX));
    endfunction

    function automatic logic [VAL_W-1:0] pow10(input logic [POS_W-1:0] pos);
        logic [VAL_W-1:0] p;
        case (pos)
            3'd0:    p = VAL_W'(1);
            3'd1:    p = VAL_W'(RADIX);
            3'd2:    p = VAL_W'(RADIX * RADIX);
            3'd3:    p = VAL_W'(RADIX * RADIX * RADIX);
            default: p = VAL_W'(RADIX * RADIX * RADIX * RADIX);
        endcase
        return p;
    endfunction

endpackage

/* rtl/afrle_front.sv */
module afrle_front #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  logic [7:0]          data_byte,
    input  logic                end_of_chunk,
    input  logic                q_full,
    output logic                q_push,
    output afrle_pkg::rle_cmd_t q_data
);
    import afrle_pkg::*;

    localparam longint unsigned CNT_LIM = (longint'(1) << COUNT_WIDTH) - 1;
    localparam longint unsigned RUN_CAP = (CNT_LIM > DIGIT_CAP) ? DIGIT_CAP : CNT_LIM;
    localparam logic [COUNT_WIDTH-1:0] RUN_MAX = COUNT_WIDTH'(RUN_CAP);

    logic [7:0]             run_letter_reg, run_letter_next;
    logic [COUNT_WIDTH-1:0] run_len_reg, run_len_next;
    logic                   pend_valid_reg, pend_valid_next;
    rle_cmd_t               pend_cmd_reg, pend_cmd_next;

    logic                   accept, letter, extend, close, flush;
    logic [7:0]             new_letter;
    logic [COUNT_WIDTH-1:0] new_len;
    rle_cmd_t               cmd_a, cmd_b;

    assign item_stall = pend_valid_reg || q_full;
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        letter = is_letter(data_byte);
        extend = letter && (run_len_reg != '0) && (data_byte == run_letter_reg)
                 && (run_len_reg < RUN_MAX);
        close  = letter && !extend && (run_len_reg != '0);

        if (extend)
        begin
            new_letter = run_letter_reg;
            new_len    = COUNT_WIDTH'(run_len_reg + 1'b1);
        end
        else if (letter)
        begin
            new_letter = data_byte;
            new_len    = COUNT_WIDTH'(1);
        end
        else
        begin
            new_letter = run_letter_reg;
            new_len    = run_len_reg;
        end
        flush = end_of_chunk && (new_len != '0);

        cmd_a.letter = run_letter_reg;
        cmd_a.len    = VAL_W'(run_len_reg);
        cmd_a.last   = !flush;
        cmd_a.chunk  = 1'b0;
        cmd_b.letter = new_letter;
        cmd_b.len    = VAL_W'(new_len);
        cmd_b.last   = 1'b1;
        cmd_b.chunk  = 1'b1;

        run_letter_next = run_letter_reg;
        run_len_next    = run_len_reg;
        pend_valid_next = pend_valid_reg;
        pend_cmd_next   = pend_cmd_reg;
        q_push          = 1'b0;
        q_data          = cmd_a;

        if (pend_valid_reg)
        begin
            q_data = pend_cmd_reg;
            if (!q_full)
            begin
                q_push          = 1'b1;
                pend_valid_next = 1'b0;
            end
        end
        else if (accept)
        begin
            if (close)
            begin
                q_push = 1'b1;
                q_data = cmd_a;
                if (flush)
                begin
                    pend_valid_next = 1'b1;
                    pend_cmd_next   = cmd_b;
                end
            end
            else if (flush)
            begin
                q_push = 1'b1;
                q_data = cmd_b;
            end
            if (flush)
            begin
                run_letter_next = '0;
                run_len_next    = '0;
            end
            else
            begin
                run_letter_next = new_letter;
                run_len_next    = new_len;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_letter_reg <= '0;
            run_len_reg    <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            run_letter_reg <= run_letter_next;
            run_len_reg    <= run_len_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_cmd_reg <= pend_cmd_next;
    end

endmodule

/* rtl/afrle_queue.sv */
module afrle_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  afrle_pkg::rle_cmd_t push_data,
    output logic                full,
    input  logic                pop,
    output afrle_pkg::rle_cmd_t pop_data,
    output logic                empty
);
    import afrle_pkg::*;

    localparam int PTR_W = $clog2(QDEPTH);
    localparam int CNT_W = $clog2(QDEPTH + 1);

    rle_cmd_t           slot_reg [QDEPTH];
    logic [PTR_W-1:0]   wptr_reg, wptr_next;
    logic [PTR_W-1:0]   rptr_reg, rptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full     = (count_reg == CNT_W'(QDEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wptr_next  = do_push ? PTR_W'(wptr_reg + 1'b1) : wptr_reg;
        rptr_next  = do_pop  ? PTR_W'(rptr_reg + 1'b1) : rptr_reg;
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = CNT_W'(count_reg + 1'b1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/afrle_back.sv */
module afrle_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  afrle_pkg::rle_cmd_t q_data,
    output logic                q_pop,
    output logic                result_valid,
    input  logic                result_stall,
    output logic [7:0]          out_byte,
    output logic                burst_last,
    output logic                chunk_done
);
    import afrle_pkg::*;

    back_state_t      state_reg, state_next;
    logic [VAL_W-1:0] rem_reg, rem_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       letter_reg, letter_next;
    logic             last_reg, last_next;
    logic             chunk_reg, chunk_next;
    logic             valid_reg, valid_next;
    logic [7:0]       byte_reg, byte_next;
    logic             blast_reg, blast_next;
    logic             cdone_reg, cdone_next;

    logic             adv;
    logic [VAL_W-1:0] pow_sel;
    logic [3:0]       digit;
    logic [POS_W-1:0] load_pos;

    assign result_valid = valid_reg;
    assign out_byte     = byte_reg;
    assign burst_last   = blast_reg;
    assign chunk_done   = cdone_reg;
    assign adv          = !valid_reg || !result_stall;
    assign pow_sel      = pow10(pos_reg);

    always_comb
    begin
        digit = '0;
        for (int k = 1; k < RADIX; k++)
        begin
            if (rem_reg >= VAL_W'(k) * pow_sel)
            begin
                digit = 4'(k);
            end
        end
    end

    always_comb
    begin
        if (q_data.len >= pow10(3'd4))
        begin
            load_pos = 3'd4;
        end
        else if (q_data.len >= pow10(3'd3))
        begin
            load_pos = 3'd3;
        end
        else if (q_data.len >= pow10(3'd2))
        begin
            load_pos = 3'd2;
        end
        else if (q_data.len >= pow10(3'd1))
        begin
            load_pos = 3'd1;
        end
        else
        begin
            load_pos = 3'd0;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        rem_next    = rem_reg;
        pos_next    = pos_reg;
        letter_next = letter_reg;
        last_next   = last_reg;
        chunk_next  = chunk_reg;
        valid_next  = adv ? 1'b0 : valid_reg;
        byte_next   = byte_reg;
        blast_next  = blast_reg;
        cdone_next  = cdone_reg;
        q_pop       = 1'b0;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop       = 1'b1;
                    rem_next    = q_data.len;
                    pos_next    = load_pos;
                    letter_next = q_data.letter;
                    last_next   = q_data.last;
                    chunk_next  = q_data.chunk;
                    if (q_data.len == VAL_W'(1))
                    begin
                        state_next = BK_LETTER;
                    end
                    else if (q_data.len == VAL_W'(2))
                    begin
                        state_next = BK_REPEAT;
                    end
                    else
                    begin
                        state_next = BK_DIGIT;
                    end
                end
            end
            BK_DIGIT:
            begin
                if (adv)
                begin
                    valid_next = 1'b1;
                    byte_next  = ASCII_ZERO + {4'b0, digit};
                    blast_next = 1'b0;
                    cdone_next = 1'b0;
                    rem_next   = rem_reg - VAL_W'(digit) * pow_sel;
                    if (pos_reg == '0)
                    begin
                        state_next = BK_LETTER;
                    end
                    else
                    begin
                        pos_next = POS_W'(pos_reg - 1'b1);
                    end
                end
            end
            BK_REPEAT:
            begin
                if (adv)
                begin
                    valid_next = 1'b1;
                    byte_next  = letter_reg;
                    blast_next = 1'b0;
                    cdone_next = 1'b0;
                    state_next = BK_LETTER;
                end
            end
            BK_LETTER:
            begin
                if (adv)
                begin
                    valid_next = 1'b1;
                    byte_next  = letter_reg;
                    blast_next = last_reg;
                    cdone_next = chunk_reg;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        pos_reg    <= pos_next;
        letter_reg <= letter_next;
        last_reg   <= last_next;
        chunk_reg  <= chunk_next;
        byte_reg   <= byte_next;
        blast_reg  <= blast_next;
        cdone_reg  <= cdone_next;
    end

endmodule

/* rtl/alpha_filter_run_length_encoder.sv */
// A run's first byte passes the command queue, which holds 4 runs, the back end's
// load state and its output register. Front takes one request per cycle unless
// the queue is full or a command is pending; a letter closing a run with a flush
// pushes two. Back end: digits for runs over two, then the letter (twice for two).
// Reset (rst_n low, asynchronous): no run pending, queue empty, no result valid.
module alpha_filter_run_length_encoder #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  logic [7:0] data_byte,
    input  logic       end_of_chunk,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [7:0] out_byte,
    output logic       burst_last,
    output logic       chunk_done
);
    import afrle_pkg::*;

    rle_cmd_t push_data, pop_data;
    logic     push, pop, full, empty;

    afrle_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .data_byte    (data_byte),
        .end_of_chunk (end_of_chunk),
        .q_full       (full),
        .q_push       (push),
        .q_data       (push_data)
    );

    afrle_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    afrle_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (empty),
        .q_data       (pop_data),
        .q_pop        (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_byte     (out_byte),
        .burst_last   (burst_last),
        .chunk_done   (chunk_done)
    );

endmodule

/* rtl/afrle_checker.sv */
module afrle_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       item_valid,
    input logic       item_stall,
    input logic [7:0] data_byte,
    input logic       end_of_chunk,
    input logic       result_valid,
    input logic       result_stall,
    input logic [7:0] out_byte,
    input logic       burst_last,
    input logic       chunk_done
);
    import afrle_pkg::*;

    logic unused_in;
    assign unused_in = item_valid ^ item_stall ^ end_of_chunk ^ (^data_byte);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    a_hold_byte: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(out_byte))
        else $error("stalled result byte changed");

    a_byte_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (is_letter(out_byte) || is_digit(out_byte)))
        else $error("result byte is neither letter nor digit");

    a_digit_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && is_digit(out_byte) |-> !burst_last && !chunk_done)
        else $error("run count digit closes a burst");

    a_chunk_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && chunk_done |-> burst_last)
        else $error("chunk end without burst end");

endmodule

bind alpha_filter_run_length_encoder afrle_checker u_afrle_checker (.*);

/* test/testbench.sv */
module testbench;

    localparam int COUNT_WIDTH = 16;
    localparam longint unsigned COUNT_LIM = (64'd1 << COUNT_WIDTH) - 1;
    localparam int unsigned RUN_MAX = (COUNT_LIM > 99999) ? 99999 : int'(COUNT_LIM);
    localparam int RANDOM_REQUESTS = 110;

    typedef struct {
        logic [7:0] b;
        logic       eoc;
        int         gap;
    } feed_t;

    typedef struct {
        logic [7:0] ch;
        logic       last;
        logic       done;
    } enc_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       item_valid = 1'b0;
    logic       item_stall;
    logic [7:0] data_byte = 8'd0;
    logic       end_of_chunk = 1'b0;
    logic       result_valid;
    logic       result_stall = 1'b0;
    logic [7:0] out_byte;
    logic       burst_last;
    logic       chunk_done;

    feed_t       byte_feed[$];
    enc_t        pending_bytes[$];
    enc_t        burst[$];
    feed_t       pend;
    bit          pend_ok = 1'b0;
    int          gap_left = 0;
    int          stall_left = 0;
    bit          calm = 1'b0;
    bit          quiet = 1'b0;
    logic [7:0]  cur_letter = 8'd0;
    int unsigned cur_count = 0;
    int          n_queued = 0;
    int          n_taken = 0;
    int          n_results = 0;
    int          err_cnt = 0;
    enc_t        want;

    alpha_filter_run_length_encoder #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .data_byte(data_byte),
        .end_of_chunk(end_of_chunk),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .out_byte(out_byte),
        .burst_last(burst_last),
        .chunk_done(chunk_done)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic bit is_alpha(logic [7:0] b);
        return (b >= 8'd65 && b <= 8'd90) || (b >= 8'd97 && b <= 8'd122);
    endfunction

    function automatic logic [7:0] pick_letter();
        if ($urandom_range(0, 1))
            return 8'd65 + 8'($urandom_range(0, 25));
        return 8'd97 + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] pick_noise();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (is_alpha(b));
        return b;
    endfunction

    function automatic void put_run();
        string digits;
        if (cur_count == 0)
            return;
        if (cur_count >= 3)
        begin
            digits = $sformatf("%0d", cur_count);
            for (int i = 0; i < digits.len(); i++)
                burst.push_back('{digits[i], 1'b0, 1'b0});
        end
        else if (cur_count == 2)
            burst.push_back('{cur_letter, 1'b0, 1'b0});
        burst.push_back('{cur_letter, 1'b0, 1'b0});
    endfunction

    function automatic void encode_request(logic [7:0] b, logic eoc);
        burst.delete();
        if (is_alpha(b))
        begin
            if (cur_count != 0 && b == cur_letter && cur_count < RUN_MAX)
                cur_count++;
            else
            begin
                put_run();
                cur_letter = b;
                cur_count = 1;
            end
        end
        if (eoc && cur_count != 0)
        begin
            put_run();
            burst[burst.size() - 1].done = 1'b1;
            cur_count = 0;
            cur_letter = 8'd0;
        end
        if (burst.size() > 0)
            burst[burst.size() - 1].last = 1'b1;
        foreach (burst[i])
            pending_bytes.push_back(burst[i]);
    endfunction

    task automatic add(logic [7:0] b, logic eoc, bit busy);
        feed_t f;
        if ($urandom_range(0, 39) == 0)
            calm = !calm;
        f.b = b;
        f.eoc = eoc;
        f.gap = (busy || calm) ? 0 : $urandom_range(0, 11);
        byte_feed.push_back(f);
        n_queued++;
    endtask

    task automatic add_run(logic [7:0] ch, int len, logic eoc_last, bit busy);
        for (int i = 0; i < len; i++)
            add(ch, eoc_last && (i == len - 1), busy);
    endtask

    // present one request at a time; hold it while stalled
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            data_byte <= 8'd0;
            end_of_chunk <= 1'b0;
        end
        else if (!item_valid || !item_stall)
        begin
            if (!pend_ok && byte_feed.size() > 0)
            begin
                pend = byte_feed.pop_front();
                pend_ok = 1'b1;
                gap_left = pend.gap;
            end
            if (pend_ok && gap_left == 0)
            begin
                item_valid <= 1'b1;
                data_byte <= pend.b;
                end_of_chunk <= pend.eoc;
                pend_ok = 1'b0;
            end
            else
            begin
                item_valid <= 1'b0;
                if (pend_ok)
                    gap_left--;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if ($urandom_range(0, 49) == 0)
                    quiet = !quiet;
                stall_left = quiet ? 0 : $urandom_range(0, 11);
            end
            if (stall_left > 0)
            begin
                result_stall <= 1'b1;
                stall_left--;
            end
            else
                result_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && !item_stall)
            begin
                n_taken++;
                encode_request(data_byte, end_of_chunk);
            end
            if (result_valid && !result_stall)
            begin
                n_results++;
                if (pending_bytes.size() == 0)
                begin
                    err_cnt++;
                    $display("%0t: unexpected byte %h last %b done %b", $time,
                             out_byte, burst_last, chunk_done);
                end
                else
                begin
                    want = pending_bytes.pop_front();
                    if (out_byte !== want.ch)
                    begin
                        err_cnt++;
                        $display("%0t: out_byte expected %h got %h", $time, want.ch, out_byte);
                    end
                    if (burst_last !== want.last)
                    begin
                        err_cnt++;
                        $display("%0t: burst_last expected %b got %b", $time, want.last,
                                 burst_last);
                    end
                    if (chunk_done !== want.done)
                    begin
                        err_cnt++;
                        $display("%0t: chunk_done expected %b got %b", $time, want.done,
                                 chunk_done);
                    end
                end
            end
        end
    end

    initial
    begin
        int n_rand;
        int kind;
        int len;
        logic [7:0] ch;

        n_rand = 0;
        add(8'd64, 1'b0, 1'b0);
        add(8'd91, 1'b0, 1'b0);
        add(8'd96, 1'b0, 1'b0);
        add(8'd123, 1'b1, 1'b0);
        add(8'd0, 1'b0, 1'b0);
        add(8'd255, 1'b1, 1'b0);
        add("A", 1'b0, 1'b0);
        add("Z", 1'b0, 1'b0);
        add("a", 1'b0, 1'b0);
        add("z", 1'b1, 1'b0);
        add_run("b", 2, 1'b1, 1'b0);
        add_run("C", 3, 1'b0, 1'b0);
        add_run("c", 2, 1'b1, 1'b0);
        add_run("Q", 3, 1'b0, 1'b0);
        add("R", 1'b1, 1'b0);
        for (int i = 0; i < 10; i++)
        begin
            add("x", i == 9, 1'b0);
            if (i == 4)
                add(pick_noise(), 1'b0, 1'b0);
        end

        while (n_rand < RANDOM_REQUESTS)
        begin
            kind = $urandom_range(0, 9);
            if (kind == 0)
            begin
                add(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
                n_rand++;
            end
            else if (kind == 1)
            begin
                add(pick_noise(), 1'b1, 1'b0);
                n_rand++;
            end
            else
            begin
                ch = pick_letter();
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(3, 40)
                                                   : $urandom_range(1, 5);
                for (int i = 0; i < len; i++)
                begin
                    if ($urandom_range(0, 7) == 0)
                        add(pick_noise(), 1'b0, 1'b0);
                    add(ch, (i == len - 1) && ($urandom_range(0, 3) == 0), 1'b0);
                    n_rand++;
                end
            end
        end

        add_run("Z", 100, 1'b0, 1'b1);
        add("a", 1'b1, 1'b0);
        add(pick_noise(), 1'b1, 1'b0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (n_taken < n_queued)
            @(posedge clk);
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("testbench: %0d requests taken, %0d encoded bytes checked",
                 n_taken, n_results);
        $display("testbench: covered filter edges, counts of one to three digits, idle flushes");
        if (err_cnt == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule

/* alpha_filter_run_length_encoder.f */
rtl/afrle_pkg.sv
rtl/afrle_front.sv
rtl/afrle_queue.sv
rtl/afrle_back.sv
rtl/alpha_filter_run_length_encoder.sv
rtl/afrle_checker.sv
test/testbench.sv
